FILE: src/fkc_pkg.sv
// Shared types, constants and helper functions of the two-link arm kinematics unit.
package fkc_pkg;

    // Default parameter values.
    localparam int MAX_POINTS_DEF   = 64;
    localparam int CORDIC_STEPS_DEF = 16;

    // Field and datapath widths.
    localparam int LEN_W     = 31;
    localparam int POS_W     = 32;
    localparam int ANG_W     = 16;
    localparam int NPT_W     = 7;
    localparam int TRIG_W    = 34;
    localparam int ZANG_W    = 35;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LINK1  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINK2  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd2;

    // Register reset values.
    localparam logic [LEN_W-1:0] LINK1_RST  = 31'd65536;
    localparam logic [LEN_W-1:0] LINK2_RST  = 31'd65536;
    localparam logic [LEN_W-1:0] RADIUS_RST = 31'd32768;

    // CORDIC start vector length in Q4.30, the inverse of the infinite gain.
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [POS_W-1:0] base_x;
        logic signed [POS_W-1:0] base_y;
        logic signed [ANG_W-1:0] joint1_angle;
        logic signed [ANG_W-1:0] joint2_angle;
        logic [NPT_W-1:0]        num_points;
    } t_fkc_in;

    typedef struct packed {
        logic signed [POS_W-1:0] elbow_x;
        logic signed [POS_W-1:0] elbow_y;
        logic signed [POS_W-1:0] tip_x;
        logic signed [POS_W-1:0] tip_y;
        logic signed [ANG_W-1:0] tip_heading;
        logic                    self_collision;
    } t_fkc_out;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0: v = 32'h20000000;
                5'd1: v = 32'h12E4051E;
                5'd2: v = 32'h09FB385B;
                5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;
                5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;
                5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;
                5'd9: v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

    // Saturate a 36-bit position to the 32-bit output range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [35:0] v);
        logic signed [POS_W-1:0] r;
        begin
            if (v > 36'sd2147483647) begin
                r = 32'sh7FFFFFFF;
            end else if (v < -36'sd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = v[POS_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

FILE: src/fkc_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module fkc_cordic #(
    parameter int STEPS = fkc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fkc_pkg::ANG_W-1:0]  i_angle,
    output logic                              o_done,
    output logic signed [fkc_pkg::TRIG_W-1:0] o_cos,
    output logic signed [fkc_pkg::TRIG_W-1:0] o_sin
);
    import fkc_pkg::*;

    localparam int ITER = (STEPS > 32) ? 32 : STEPS;
    localparam int CW   = $clog2(ITER + 1);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FLIP} t_cstate;

    t_cstate                    r_state;
    logic [CW-1:0]              r_i;
    logic signed [TRIG_W-1:0]   r_x;
    logic signed [TRIG_W-1:0]   r_y;
    logic signed [ZANG_W-1:0]   r_z;
    logic                       r_flip;
    logic                       r_done;

    logic [4:0]                 w_sh;
    logic signed [TRIG_W-1:0]   w_xs;
    logic signed [TRIG_W-1:0]   w_ys;
    logic signed [ZANG_W-1:0]   w_atan;
    logic signed [16:0]         w_ang;
    logic signed [16:0]         w_adj;
    logic                       w_flip;

    // Fold the angle into the half turn the iterations converge on.
    always_comb begin
        w_ang  = 17'(i_angle);
        w_adj  = w_ang;
        w_flip = 1'b0;
        if (i_angle >= 16'sd16384) begin
            w_adj  = w_ang - 17'sd32768;
            w_flip = 1'b1;
        end else if (i_angle < -16'sd16384) begin
            w_adj  = w_ang + 17'sd32768;
            w_flip = 1'b1;
        end
    end

    assign w_sh   = 5'(r_i);
    assign w_xs   = r_x >>> w_sh;
    assign w_ys   = r_y >>> w_sh;
    assign w_atan = signed'(ZANG_W'(atan_turn(w_sh)));

    // One micro-rotation per cycle, then the optional half-turn correction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= ZANG_W'(signed'({w_adj, 16'b0}));
                        r_flip  <= w_flip;
                        r_i     <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (!r_z[ZANG_W-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CW'(ITER - 1)) begin
                        r_state <= C_FLIP;
                    end
                end
                C_FLIP: begin
                    if (r_flip) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

FILE: src/fkc_div.sv
// Restoring divider, one quotient bit per cycle.
module fkc_div #(
    parameter int NW = 34,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    import fkc_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [DW:0]       w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Shift the dividend in, subtract when the partial remainder allows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_run) begin
                if (i_start) begin
                    r_num <= i_num;
                    r_den <= i_den;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_run <= 1'b1;
                end
            end else begin
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
                r_num <= {r_num[NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: src/planar_two_link_fk_collision_unit.sv
// Top level: sequencer, shared multiplier and point checker of the arm kinematics unit.
//
// An item is taken when start is high and busy is low; its result appears on
// o_result with o_done high for one cycle, and the receiver cannot stall it.
// One item keeps the unit busy through two CORDIC runs on one iterative unit,
// five products on one 33x33 multiplier, two bit-serial divides for the
// sample step (skipped for fewer than two points) and, for each sample, a
// load, a square of each axis and a compare step, since both squares share
// the same multiplier. The CORDIC step count is at most 32, and the number
// of samples checked is the clamped point count, fewer once a hit is found.
// Configuration writes are always accepted and must only be made while busy
// is low.
module planar_two_link_fk_collision_unit #(
    parameter int MAX_POINTS   = fkc_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = fkc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  fkc_pkg::t_fkc_in                     i_in,
    output logic                                 o_done,
    output fkc_pkg::t_fkc_out                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fkc_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [fkc_pkg::LEN_W-1:0]            i_cfg_data
);
    import fkc_pkg::*;

    localparam int PW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_COR1, S_COR2, S_MEX, S_MEY, S_MDX, S_MDY, S_MR2,
        S_DIVX, S_DIVY, S_PLOAD, S_PSQX, S_PSQY, S_PCMP, S_FIN
    } t_state;

    t_state                   r_state;
    t_fkc_in                  r_in;
    logic [PW-1:0]            r_n;
    logic [PW-1:0]            r_m;
    logic [PW-1:0]            r_k;
    logic [LEN_W-1:0]         r_len1;
    logic [LEN_W-1:0]         r_len2;
    logic [LEN_W-1:0]         r_rad;
    logic signed [TRIG_W-1:0] r_c1, r_s1, r_c12, r_s12;
    logic signed [TRIG_W-1:0] r_ex, r_ey, r_dx, r_dy;
    logic [61:0]              r_r2;
    logic                     r_cor_go;
    logic                     r_div_go;
    logic [TRIG_W-1:0]        r_stepqx, r_stepqy;
    logic [PW-1:0]            r_steprx, r_stepry;
    logic [TRIG_W-1:0]        r_qx, r_qy;
    logic [PW-1:0]            r_rx, r_ry;
    logic [30:0]              r_ux, r_uy;
    logic                     r_far;
    logic [61:0]              r_sqx, r_sqy;
    logic                     r_hit;
    logic                     r_done;
    t_fkc_out                 r_result;

    logic signed [ANG_W-1:0]  w_a12;
    logic                     w_cor_done;
    logic signed [TRIG_W-1:0] w_cos, w_sin;
    logic                     w_div_done;
    logic [TRIG_W-1:0]        w_quo;
    logic [PW-1:0]            w_rem;
    logic [TRIG_W-1:0]        w_div_num;
    logic signed [32:0]       w_ma, w_mb;
    logic signed [65:0]       w_prod;
    logic signed [65:0]       w_prod_shr;
    logic signed [TRIG_W-1:0] w_term;
    logic signed [35:0]       w_offx, w_offy, w_px, w_py;
    logic [35:0]              w_abx, w_aby;
    logic [PW:0]              w_rxs, w_rys;
    logic [62:0]              w_dist;
    logic signed [35:0]       w_elx, w_ely, w_tpx, w_tpy;

    assign w_a12 = r_in.joint1_angle + r_in.joint2_angle;

    fkc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_angle ((r_state == S_COR1) ? r_in.joint1_angle : w_a12),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // Magnitude of the link 2 offset on the axis being divided.
    always_comb begin
        if (r_state == S_DIVX) begin
            w_div_num = r_dx[TRIG_W-1] ? TRIG_W'(-r_dx) : r_dx;
        end else begin
            w_div_num = r_dy[TRIG_W-1] ? TRIG_W'(-r_dy) : r_dy;
        end
    end

    fkc_div #(.NW(TRIG_W), .DW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_div_num),
        .i_den   (r_m),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Shared multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MEX: begin
                w_ma = signed'({2'b0, r_len1});
                w_mb = r_c1[32:0];
            end
            S_MEY: begin
                w_ma = signed'({2'b0, r_len1});
                w_mb = r_s1[32:0];
            end
            S_MDX: begin
                w_ma = signed'({2'b0, r_len2});
                w_mb = r_c12[32:0];
            end
            S_MDY: begin
                w_ma = signed'({2'b0, r_len2});
                w_mb = r_s12[32:0];
            end
            S_MR2: begin
                w_ma = signed'({2'b0, r_rad});
                w_mb = signed'({2'b0, r_rad});
            end
            S_PSQX: begin
                w_ma = signed'({2'b0, r_ux});
                w_mb = signed'({2'b0, r_ux});
            end
            S_PSQY: begin
                w_ma = signed'({2'b0, r_uy});
                w_mb = signed'({2'b0, r_uy});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod     = w_ma * w_mb;
    assign w_prod_shr = w_prod >>> 30;
    assign w_term     = w_prod_shr[TRIG_W-1:0];

    // Current sample offset from the base and its magnitude per axis.
    always_comb begin
        w_offx = r_dx[TRIG_W-1] ? -signed'({2'b0, r_qx}) : signed'({2'b0, r_qx});
        w_offy = r_dy[TRIG_W-1] ? -signed'({2'b0, r_qy}) : signed'({2'b0, r_qy});
        w_px   = 36'(r_ex) + w_offx;
        w_py   = 36'(r_ey) + w_offy;
        w_abx  = w_px[35] ? 36'(-w_px) : 36'(w_px);
        w_aby  = w_py[35] ? 36'(-w_py) : 36'(w_py);
        w_rxs  = {1'b0, r_rx} + {1'b0, r_steprx};
        w_rys  = {1'b0, r_ry} + {1'b0, r_stepry};
    end

    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Final positions before saturation.
    assign w_elx = 36'(r_in.base_x) + 36'(r_ex);
    assign w_ely = 36'(r_in.base_y) + 36'(r_ey);
    assign w_tpx = w_elx + 36'(r_dx);
    assign w_tpy = w_ely + 36'(r_dy);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= LINK1_RST;
            r_len2 <= LINK2_RST;
            r_rad  <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LINK1:  r_len1 <= i_cfg_data;
                REG_LINK2:  r_len2 <= i_cfg_data;
                REG_RADIUS: r_rad  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Main sequencer with the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cor_go <= 1'b0;
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_cor_go <= 1'b0;
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in <= i_in;
                        if (int'(i_in.num_points) > MAX_POINTS) begin
                            r_n <= PW'(MAX_POINTS);
                        end else begin
                            r_n <= PW'(i_in.num_points);
                        end
                        r_cor_go <= 1'b1;
                        r_state  <= S_COR1;
                    end
                end
                S_COR1: begin
                    if (w_cor_done) begin
                        r_c1     <= w_cos;
                        r_s1     <= w_sin;
                        r_cor_go <= 1'b1;
                        r_state  <= S_COR2;
                    end
                end
                S_COR2: begin
                    if (w_cor_done) begin
                        r_c12   <= w_cos;
                        r_s12   <= w_sin;
                        r_state <= S_MEX;
                    end
                end
                S_MEX: begin
                    r_ex    <= w_term;
                    r_state <= S_MEY;
                end
                S_MEY: begin
                    r_ey    <= w_term;
                    r_state <= S_MDX;
                end
                S_MDX: begin
                    r_dx    <= w_term;
                    r_state <= S_MDY;
                end
                S_MDY: begin
                    r_dy    <= w_term;
                    r_state <= S_MR2;
                end
                S_MR2: begin
                    r_r2  <= w_prod[61:0];
                    r_m   <= r_n - 1'b1;
                    r_hit <= 1'b0;
                    r_k   <= '0;
                    r_qx  <= '0;
                    r_qy  <= '0;
                    r_rx  <= '0;
                    r_ry  <= '0;
                    r_stepqx <= '0;
                    r_stepqy <= '0;
                    r_steprx <= '0;
                    r_stepry <= '0;
                    if (r_n == '0) begin
                        r_state <= S_FIN;
                    end else if (r_n == PW'(1)) begin
                        r_state <= S_PLOAD;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (w_div_done) begin
                        r_stepqx <= w_quo;
                        r_steprx <= w_rem;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_done) begin
                        r_stepqy <= w_quo;
                        r_stepry <= w_rem;
                        r_state  <= S_PLOAD;
                    end
                end
                S_PLOAD: begin
                    r_ux  <= w_abx[30:0];
                    r_uy  <= w_aby[30:0];
                    r_far <= (|w_abx[35:31]) | (|w_aby[35:31]);
                    // Step to the next sample: quotient and remainder of dx*k/m.
                    if (w_rxs >= {1'b0, r_m}) begin
                        r_rx <= PW'(w_rxs - {1'b0, r_m});
                        r_qx <= r_qx + r_stepqx + 1'b1;
                    end else begin
                        r_rx <= w_rxs[PW-1:0];
                        r_qx <= r_qx + r_stepqx;
                    end
                    if (w_rys >= {1'b0, r_m}) begin
                        r_ry <= PW'(w_rys - {1'b0, r_m});
                        r_qy <= r_qy + r_stepqy + 1'b1;
                    end else begin
                        r_ry <= w_rys[PW-1:0];
                        r_qy <= r_qy + r_stepqy;
                    end
                    r_state <= S_PSQX;
                end
                S_PSQX: begin
                    r_sqx   <= w_prod[61:0];
                    r_state <= S_PSQY;
                end
                S_PSQY: begin
                    r_sqy   <= w_prod[61:0];
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    r_k <= r_k + 1'b1;
                    if (!r_far && (w_dist < {1'b0, r_r2})) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FIN;
                    end else if (r_k + 1'b1 == r_n) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_PLOAD;
                    end
                end
                S_FIN: begin
                    r_result.elbow_x        <= sat_pos(w_elx);
                    r_result.elbow_y        <= sat_pos(w_ely);
                    r_result.tip_x          <= sat_pos(w_tpx);
                    r_result.tip_y          <= sat_pos(w_tpy);
                    r_result.tip_heading    <= w_a12;
                    r_result.self_collision <= r_hit;
                    r_done                  <= 1'b1;
                    r_state                 <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: src/fkc_check.sv
// Port-level checks of the arm kinematics unit and their binding.
module fkc_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);
    import fkc_pkg::*;

    // A result is shown only once the unit has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the unit busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but unit not busy");

    // Finishing an item always delivers its result.
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_done)
        else $error("unit went idle without a result");

    // One result per item: the strobe is never repeated back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

endmodule

bind planar_two_link_fk_collision_unit fkc_check u_fkc_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
